### src/irdig_pkg.sv
// Shared types, sizes and the digit character table for the radix digit converter.
package irdig_pkg;

   localparam int VALUE_BITS = 31;
   localparam int CNT_W      = $clog2(VALUE_BITS);
   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

   localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(57);
   localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);
   localparam logic [CHAR_W-1:0] CHAR_F    = CHAR_W'(70);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      case (d)
         4'h0: c = CHAR_W'(48);
         4'h1: c = CHAR_W'(49);
         4'h2: c = CHAR_W'(50);
         4'h3: c = CHAR_W'(51);
         4'h4: c = CHAR_W'(52);
         4'h5: c = CHAR_W'(53);
         4'h6: c = CHAR_W'(54);
         4'h7: c = CHAR_W'(55);
         4'h8: c = CHAR_W'(56);
         4'h9: c = CHAR_W'(57);
         4'hA: c = CHAR_W'(65);
         4'hB: c = CHAR_W'(66);
         4'hC: c = CHAR_W'(67);
         4'hD: c = CHAR_W'(68);
         4'hE: c = CHAR_W'(69);
         default: c = CHAR_W'(70);
      endcase
      return c;
   endfunction

endpackage

### src/integer_to_radix_digits.sv
// Integer to radix digit converter: bit-serial divider, digit store and emit sequencer.
//
// Usage:
//   Pulse start with req_value while busy is low; the item is taken at that edge.
//   The base comes from the csr_radix register (reset value 10), written when
//   csr_valid and csr_ready are both high; csr_ready is always high. Values
//   below 2 act as 2 and values above 16 act as 16. Write it only while idle.
//   One restoring divider step per cycle; each digit is the remainder of one
//   full division, least significant digit first, into a small digit store.
//   Then the digits are sent most significant first, one per cycle, each marked
//   by rsp_valid for exactly one cycle; rsp_last_digit flags the final one.
//   An n-digit result has 1 <= n <= 31; busy stays high from the accepting
//   edge through the last digit. Zero gives one '0'.
//   A new item is taken only after the last one ends: the divider is shared.
//   The receiver cannot stall: results are not held.
//   Synchronous active-high reset returns to idle, drops any run in progress
//   and restores the base to 10.
module integer_to_radix_digits
   import irdig_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [CHAR_W-1:0]     rsp_digit_char,
   output logic                  rsp_last_digit,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_W-1:0]    csr_radix
);

   state_type              state_ff, state_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic [RADIX_W-1:0]     base_ff, base_in;
   logic [VALUE_BITS-1:0]  quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]       bit_ff, bit_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIGIT_W-1:0]     digit_ff [VALUE_BITS];

   logic [RADIX_W-1:0]     trial;
   logic [RADIX_W-1:0]     diff;
   logic                   ge;
   logic [DIGIT_W-1:0]     rem_next;
   logic [VALUE_BITS-1:0]  quot_next;
   logic                   digit_we;

   // shared divider step
   always_comb begin
      trial     = {rem_ff, quot_ff[VALUE_BITS-1]};
      ge        = (trial >= base_ff);
      diff      = trial - base_ff;
      rem_next  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      quot_next = {quot_ff[VALUE_BITS-2:0], ge};
   end

   always_comb begin
      state_in = state_ff;
      radix_in = radix_ff;
      base_in  = base_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      digit_we = 1'b0;

      if (csr_valid) begin
         radix_in = csr_radix;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quot_in  = req_value;
               rem_in   = '0;
               bit_in   = '0;
               cnt_in   = '0;
               if (radix_ff < RADIX_MIN) begin
                  base_in = RADIX_MIN;
               end else if (radix_ff > RADIX_MAX) begin
                  base_in = RADIX_MAX;
               end else begin
                  base_in = radix_ff;
               end
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quot_in = quot_next;
            rem_in  = rem_next;
            bit_in  = bit_ff + CNT_W'(1);
            if (bit_ff == CNT_W'(VALUE_BITS - 1)) begin
               // digit done: store remainder, start next division or emit
               digit_we = 1'b1;
               rem_in   = '0;
               bit_in   = '0;
               if (quot_next == '0 || cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         bit_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         bit_ff   <= bit_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (digit_we) begin
         digit_ff[cnt_ff] <= rem_next;
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_digit_char = digit_char(digit_ff[cnt_ff]);
   assign rsp_last_digit = (state_ff == ST_EMIT) && (cnt_ff == '0);

`ifndef SYNTH
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_digit) |=> !busy)
      else $error("still busy after last digit");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not start a division");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= CHAR_ZERO && rsp_digit_char <= CHAR_NINE) ||
                     (rsp_digit_char >= CHAR_A && rsp_digit_char <= CHAR_F)))
      else $error("digit character out of range");

   a_base_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (base_ff >= RADIX_MIN && base_ff <= RADIX_MAX))
      else $error("divider base out of range");
`endif

endmodule
